// ----- design/pai_pkg.sv -----
// Shared types, codes and arithmetic helpers for the particle axis integrator.
package pai_pkg;

  localparam logic [3:0] MODE_GROUND   = 4'd0;
  localparam logic [3:0] MODE_EULER    = 4'd1;
  localparam logic [3:0] MODE_MIDPOINT = 4'd2;
  localparam logic [3:0] MODE_RK3      = 4'd3;
  localparam logic [3:0] MODE_RK4      = 4'd4;
  localparam logic [3:0] MODE_SEMI     = 4'd5;
  localparam logic [3:0] MODE_TRAP     = 4'd6;
  localparam logic [3:0] MODE_VERLET   = 4'd7;
  localparam logic [3:0] MODE_RKGEN    = 4'd8;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_STEP   = 3'd1;
  localparam logic [2:0] REG_KEEP   = 3'd2;
  localparam logic [2:0] REG_LAMBDA = 3'd3;
  localparam logic [2:0] REG_INV    = 3'd4;
  localparam logic [2:0] REG_HMI    = 3'd5;
  localparam logic [2:0] REG_HALF   = 3'd6;
  localparam logic [2:0] REG_OMH    = 3'd7;

  localparam logic [4:0] RS16 = 5'd16;
  localparam logic [4:0] RS17 = 5'd17;

  localparam logic signed [51:0] SAT_MAX = 52'sd2147483647;
  localparam logic signed [51:0] SAT_MIN = -52'sd2147483648;

  typedef struct packed {
    logic        [15:0] h;
    logic        [16:0] hh;
    logic        [16:0] keep;
    logic signed [20:0] lam;
    logic signed [20:0] inv;
    logic signed [20:0] hmi;
    logic signed [20:0] half;
    logic signed [20:0] omh;
    logic signed [21:0] four_l;
  } coef_t;

  typedef struct packed {
    logic        [3:0]  md;
    logic signed [31:0] p;
    logic signed [31:0] v;
    logic signed [31:0] pd;
    logic signed [31:0] a;
    logic signed [31:0] p0;
    logic signed [31:0] v0;
    logic signed [31:0] a0;
  } in_t;

  typedef struct packed {
    logic        [3:0]  md;
    logic signed [31:0] p;
    logic signed [31:0] v;
    logic signed [31:0] pd;
    logic signed [31:0] a;
    logic signed [32:0] ha16;
    logic signed [32:0] ha17;
    logic signed [32:0] hpd;
    logic signed [33:0] hha16;
    logic signed [33:0] hha17;
    logic signed [35:0] kdp;
    logic signed [35:0] kdv;
    logic signed [33:0] hhda17;
    logic signed [36:0] ma;
    logic signed [36:0] ia;
    logic signed [36:0] ga;
    logic signed [37:0] fa;
  } s1_t;

  typedef struct packed {
    logic        [3:0]  md;
    logic signed [31:0] p;
    logic signed [31:0] v;
    logic signed [31:0] a;
    logic signed [33:0] k1;
    logic signed [33:0] k2;
    logic signed [34:0] t;
    logic signed [37:0] s3;
    logic signed [38:0] c;
    logic signed [36:0] ga;
    logic signed [37:0] fa;
    logic signed [37:0] np_m;
    logic signed [37:0] nv_m;
  } s2_t;

  typedef struct packed {
    logic        [3:0]  md;
    logic signed [31:0] p;
    logic signed [31:0] v;
    logic signed [31:0] a;
    logic signed [33:0] k1;
    logic signed [37:0] s3;
    logic signed [36:0] ga;
    logic signed [37:0] fa;
    logic signed [43:0] hc;
    logic signed [38:0] hc17;
    logic signed [43:0] lc;
    logic signed [39:0] fk2;
    logic signed [37:0] np_m;
    logic signed [37:0] nv_m;
  } s3_t;

  typedef struct packed {
    logic        [3:0]  md;
    logic signed [31:0] p;
    logic signed [31:0] v;
    logic signed [37:0] s3;
    logic signed [44:0] d;
    logic signed [39:0] k3;
    logic signed [41:0] kf;
    logic signed [44:0] af;
    logic signed [37:0] np_m;
    logic signed [37:0] nv_m;
  } s4_t;

  typedef struct packed {
    logic        [3:0]  md;
    logic signed [31:0] p;
    logic signed [31:0] v;
    logic signed [37:0] s3;
    logic signed [44:0] d;
    logic signed [41:0] kf;
    logic signed [44:0] af;
    logic signed [44:0] lk3;
    logic signed [45:0] hd;
    logic signed [37:0] np_m;
    logic signed [37:0] nv_m;
  } s5_t;

  typedef struct packed {
    logic        [3:0]  md;
    logic signed [31:0] p;
    logic signed [31:0] v;
    logic signed [49:0] xp;
    logic signed [49:0] xv;
    logic signed [37:0] np_m;
    logic signed [37:0] nv_m;
  } s6_t;

  typedef struct packed {
    logic        [3:0]  md;
    logic signed [31:0] p;
    logic signed [31:0] v;
    logic        [27:0] qhi_p;
    logic        [1:0]  r_p;
    logic        [23:0] lo_p;
    logic        [27:0] qhi_v;
    logic        [1:0]  r_v;
    logic        [23:0] lo_v;
    logic signed [37:0] np_m;
    logic signed [37:0] nv_m;
  } s7_t;

  typedef struct packed {
    logic        [3:0]  md;
    logic signed [31:0] p;
    logic signed [31:0] v;
    logic signed [49:0] qp;
    logic signed [49:0] qv;
    logic signed [37:0] np_m;
    logic signed [37:0] nv_m;
  } s8_t;

  typedef struct packed {
    logic signed [51:0] npf;
    logic signed [51:0] nvf;
    logic               bad;
  } s9_t;

  typedef struct packed {
    logic signed [31:0] np;
    logic signed [31:0] nv;
    logic               sat;
    logic               bad;
  } out_t;

  // Arithmetic shift right by s with rounding to nearest, ties toward plus infinity.
  function automatic logic signed [71:0] rnd(input logic signed [71:0] x, input logic [4:0] s);
    rnd = (x + (72'sd1 <<< (s - 5'd1))) >>> s;
  endfunction

  // One radix-16 step of a division by three: returns the quotient digit and remainder.
  function automatic logic [5:0] d3_step(input logic [1:0] r, input logic [3:0] n);
    logic [5:0]  w;
    logic [11:0] m;
    logic [3:0]  q;
    logic [5:0]  q3;
    logic [5:0]  rem;
    w   = {r, n};
    m   = 12'(w) * 12'd43;
    q   = m[10:7];
    q3  = {1'b0, q, 1'b0} + {2'b00, q};
    rem = w - q3;
    d3_step = {q, rem[1:0]};
  endfunction

  // Clamp to 32 bits; the top bit of the result is the clip flag.
  function automatic logic [32:0] sat32(input logic signed [51:0] x);
    if (x > SAT_MAX) begin
      sat32 = {1'b1, 32'h7FFF_FFFF};
    end else if (x < SAT_MIN) begin
      sat32 = {1'b1, 32'h8000_0000};
    end else begin
      sat32 = {1'b0, x[31:0]};
    end
  endfunction

endpackage

// ----- design/pai_front.sv -----
// Stages one and two: step products of the inputs and the simple integrator sums.
module pai_front import pai_pkg::*; (
  input  logic       clk,
  input  logic [1:0] en,
  input  coef_t      cf,
  input  in_t        din,
  output s2_t        dout
);

  s1_t s1, s1_next;
  s2_t s2_next;

  logic signed [16:0] hs;
  logic signed [17:0] hhs;
  logic signed [17:0] ks;
  logic signed [32:0] dp, dv, da;
  logic signed [48:0] pr_ha, pr_hpd;
  logic signed [49:0] pr_hha;
  logic signed [50:0] pr_kdp, pr_kdv, pr_hhda;
  logic signed [52:0] pr_ma, pr_ia, pr_ga;
  logic signed [53:0] pr_fa;
  logic signed [33:0] k1, k2;

  assign hs  = $signed({1'b0, cf.h});
  assign hhs = $signed({1'b0, cf.hh});
  assign ks  = $signed({1'b0, cf.keep});
  assign dp  = 33'(din.p) - 33'(din.p0);
  assign dv  = 33'(din.v) - 33'(din.v0);
  assign da  = 33'(din.a) - 33'(din.a0);

  assign pr_ha   = hs * din.a;
  assign pr_hpd  = hs * din.pd;
  assign pr_hha  = hhs * din.a;
  assign pr_kdp  = ks * dp;
  assign pr_kdv  = ks * dv;
  assign pr_hhda = hhs * da;
  assign pr_ma   = cf.hmi * din.a;
  assign pr_ia   = cf.inv * din.a;
  assign pr_ga   = cf.omh * din.a;
  assign pr_fa   = cf.four_l * din.a;

  always_comb begin
    s1_next.md     = din.md;
    s1_next.p      = din.p;
    s1_next.v      = din.v;
    s1_next.pd     = din.pd;
    s1_next.a      = din.a;
    s1_next.ha16   = 33'(rnd(72'(pr_ha), RS16));
    s1_next.ha17   = 33'(rnd(72'(pr_ha), RS17));
    s1_next.hpd    = 33'(rnd(72'(pr_hpd), RS16));
    s1_next.hha16  = 34'(rnd(72'(pr_hha), RS16));
    s1_next.hha17  = 34'(rnd(72'(pr_hha), RS17));
    s1_next.kdp    = 36'(rnd(72'(pr_kdp), RS16));
    s1_next.kdv    = 36'(rnd(72'(pr_kdv), RS16));
    s1_next.hhda17 = 34'(rnd(72'(pr_hhda), RS17));
    s1_next.ma     = 37'(rnd(72'(pr_ma), RS16));
    s1_next.ia     = 37'(rnd(72'(pr_ia), RS16));
    s1_next.ga     = 37'(rnd(72'(pr_ga), RS16));
    s1_next.fa     = 38'(rnd(72'(pr_fa), RS16));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1 <= s1_next;
    end
  end

  assign k1 = 34'(s1.v) + 34'(s1.ha16);
  assign k2 = 34'(s1.v) + 34'(s1.ha17);

  always_comb begin
    s2_next.md = s1.md;
    s2_next.p  = s1.p;
    s2_next.v  = s1.v;
    s2_next.a  = s1.a;
    s2_next.k1 = k1;
    s2_next.k2 = k2;
    s2_next.t  = 35'(k1) + 35'(s1.pd);
    s2_next.s3 = (38'(k1) <<< 1) + (38'(k2) <<< 2);
    s2_next.c  = (39'(s1.ma) + 39'(s1.ia)) <<< 1;
    s2_next.ga = s1.ga;
    s2_next.fa = s1.fa;
    s2_next.nv_m = 38'(k1);
    case (s1.md)
      MODE_GROUND: begin
        s2_next.np_m = 38'(s1.p) + 38'(s1.hpd) + 38'(s1.hha17);
      end
      MODE_EULER: begin
        s2_next.np_m = 38'(s1.p) + 38'(s1.hpd);
      end
      MODE_VERLET: begin
        s2_next.np_m = 38'(s1.p) + 38'(s1.kdp) + 38'(s1.hha16);
        s2_next.nv_m = 38'(s1.v) + 38'(s1.kdv) + 38'(s1.hhda17);
      end
      default: begin
        s2_next.np_m = 38'(s1.p);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dout <= s2_next;
    end
  end

endmodule

// ----- design/pai_lam.sv -----
// Stages three to six: the general Runge-Kutta chain and the shared step product.
module pai_lam import pai_pkg::*; (
  input  logic       clk,
  input  logic [3:0] en,
  input  coef_t      cf,
  input  s2_t        din,
  output s6_t        dout
);

  s3_t s3r, s3_next;
  s4_t s4r, s4_next;
  s5_t s5r, s5_next;
  s6_t s6_next;

  logic signed [16:0] hs;
  logic signed [59:0] pr_hc, pr_lc;
  logic signed [55:0] pr_hc17, pr_fk;
  logic signed [34:0] xsel;
  logic signed [51:0] pr_hx;
  logic signed [36:0] hx;
  logic signed [60:0] pr_lk;
  logic signed [61:0] pr_hd;
  logic signed [47:0] sp;
  logic signed [45:0] sv;

  assign hs = $signed({1'b0, cf.h});

  assign pr_hc   = cf.half * din.c;
  assign pr_lc   = cf.lam * din.c;
  assign pr_hc17 = hs * din.c;
  assign pr_fk   = cf.four_l * din.k2;
  assign pr_hx   = hs * xsel;

  always_comb begin
    case (din.md)
      MODE_MIDPOINT: xsel = 35'(din.k2);
      MODE_SEMI:     xsel = 35'(din.k1);
      default:       xsel = din.t;
    endcase
    if (din.md == MODE_TRAP) begin
      hx = 37'(rnd(72'(pr_hx), RS17));
    end else begin
      hx = 37'(rnd(72'(pr_hx), RS16));
    end
    s3_next.md   = din.md;
    s3_next.p    = din.p;
    s3_next.v    = din.v;
    s3_next.a    = din.a;
    s3_next.k1   = din.k1;
    s3_next.s3   = din.s3;
    s3_next.ga   = din.ga;
    s3_next.fa   = din.fa;
    s3_next.hc   = 44'(rnd(72'(pr_hc), RS16));
    s3_next.hc17 = 39'(rnd(72'(pr_hc17), RS17));
    s3_next.lc   = 44'(rnd(72'(pr_lc), RS16));
    s3_next.fk2  = 40'(rnd(72'(pr_fk), RS16));
    s3_next.nv_m = din.nv_m;
    if (din.md == MODE_MIDPOINT || din.md == MODE_SEMI || din.md == MODE_TRAP) begin
      s3_next.np_m = 38'(din.p) + 38'(hx);
    end else begin
      s3_next.np_m = din.np_m;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s3r <= s3_next;
    end
  end

  always_comb begin
    s4_next.md   = s3r.md;
    s4_next.p    = s3r.p;
    s4_next.v    = s3r.v;
    s4_next.s3   = s3r.s3;
    s4_next.d    = 45'(s3r.ga) + 45'(s3r.hc);
    s4_next.k3   = 40'(s3r.v) + 40'(s3r.hc17);
    s4_next.kf   = 42'(s3r.k1) + 42'(s3r.fk2) + 42'(s3r.v);
    s4_next.af   = 45'(s3r.a) + 45'(s3r.fa) + 45'(s3r.lc);
    s4_next.np_m = s3r.np_m;
    s4_next.nv_m = s3r.nv_m;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s4r <= s4_next;
    end
  end

  assign pr_lk = cf.lam * s4r.k3;
  assign pr_hd = hs * s4r.d;

  always_comb begin
    s5_next.md   = s4r.md;
    s5_next.p    = s4r.p;
    s5_next.v    = s4r.v;
    s5_next.s3   = s4r.s3;
    s5_next.d    = s4r.d;
    s5_next.kf   = s4r.kf;
    s5_next.af   = s4r.af;
    s5_next.lk3  = 45'(rnd(72'(pr_lk), RS16));
    s5_next.hd   = 46'(rnd(72'(pr_hd), RS16));
    s5_next.np_m = s4r.np_m;
    s5_next.nv_m = s4r.nv_m;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s5r <= s5_next;
    end
  end

  assign sp = 48'(s5r.kf) + 48'(s5r.lk3) + 48'(s5r.hd);
  assign sv = 46'(s5r.af) + 46'(s5r.d);

  always_comb begin
    s6_next.md   = s5r.md;
    s6_next.p    = s5r.p;
    s6_next.v    = s5r.v;
    s6_next.xp   = (s5r.md == MODE_RKGEN) ? 50'(sp) : 50'(s5r.s3);
    s6_next.xv   = 50'(sv);
    s6_next.np_m = s5r.np_m;
    s6_next.nv_m = s5r.nv_m;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      dout <= s6_next;
    end
  end

endmodule

// ----- design/pai_div6.sv -----
// Two-stage rounded division by six of the position and velocity sums, radix 16.
module pai_div6 import pai_pkg::*; (
  input  logic       clk,
  input  logic [1:0] en,
  input  s6_t        din,
  output s8_t        dout
);

  s7_t s7r, s7_next;
  s8_t s8_next;

  logic [51:0] yp, yv, zp, zv;
  logic [1:0]  rp, rv;
  logic [5:0]  stp, stv;
  logic [51:0] qp, qv;

  // Bias by a multiple of six so the dividend is positive; halve, then divide by three.
  assign yp = 52'(din.xp) + 52'd3 + (52'd3 << 50);
  assign yv = 52'(din.xv) + 52'd3 + (52'd3 << 50);
  assign zp = {1'b0, yp[51:1]};
  assign zv = {1'b0, yv[51:1]};

  always_comb begin
    s7_next.md    = din.md;
    s7_next.p     = din.p;
    s7_next.v     = din.v;
    s7_next.np_m  = din.np_m;
    s7_next.nv_m  = din.nv_m;
    s7_next.qhi_p = '0;
    s7_next.qhi_v = '0;
    rp = 2'd0;
    rv = 2'd0;
    stp = '0;
    stv = '0;
    for (int i = 0; i < 7; i++) begin
      stp = d3_step(rp, zp[51 - 4 * i -: 4]);
      stv = d3_step(rv, zv[51 - 4 * i -: 4]);
      s7_next.qhi_p[27 - 4 * i -: 4] = stp[5:2];
      s7_next.qhi_v[27 - 4 * i -: 4] = stv[5:2];
      rp = stp[1:0];
      rv = stv[1:0];
    end
    s7_next.r_p  = rp;
    s7_next.r_v  = rv;
    s7_next.lo_p = zp[23:0];
    s7_next.lo_v = zv[23:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s7r <= s7_next;
    end
  end

  always_comb begin
    logic [1:0] r2p, r2v;
    logic [5:0] tp, tv;
    qp  = {s7r.qhi_p, 24'd0};
    qv  = {s7r.qhi_v, 24'd0};
    r2p = s7r.r_p;
    r2v = s7r.r_v;
    tp  = '0;
    tv  = '0;
    for (int i = 0; i < 6; i++) begin
      tp = d3_step(r2p, s7r.lo_p[23 - 4 * i -: 4]);
      tv = d3_step(r2v, s7r.lo_v[23 - 4 * i -: 4]);
      qp[23 - 4 * i -: 4] = tp[5:2];
      qv[23 - 4 * i -: 4] = tv[5:2];
      r2p = tp[1:0];
      r2v = tv[1:0];
    end
    s8_next.md   = s7r.md;
    s8_next.p    = s7r.p;
    s8_next.v    = s7r.v;
    s8_next.np_m = s7r.np_m;
    s8_next.nv_m = s7r.nv_m;
    s8_next.qp   = $signed({~qp[49], qp[48:0]});
    s8_next.qv   = $signed({~qv[49], qv[48:0]});
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dout <= s8_next;
    end
  end

endmodule

// ----- design/pai_back.sv -----
// Last two stages: final step products, result selection and saturation.
module pai_back import pai_pkg::*; (
  input  logic       clk,
  input  logic [1:0] en,
  input  coef_t      cf,
  input  s8_t        din,
  output out_t       dout
);

  s9_t  s9r, s9_next;
  out_t out_next;

  logic signed [16:0] hs;
  logic signed [66:0] pr_qp, pr_qv;
  logic signed [50:0] hqp, hqv;
  logic [32:0] sp, sv;

  assign hs    = $signed({1'b0, cf.h});
  assign pr_qp = hs * din.qp;
  assign pr_qv = hs * din.qv;
  assign hqp   = 51'(rnd(72'(pr_qp), RS16));
  assign hqv   = 51'(rnd(72'(pr_qv), RS16));

  always_comb begin
    s9_next.bad = 1'b0;
    s9_next.npf = 52'(din.np_m);
    s9_next.nvf = 52'(din.nv_m);
    case (din.md)
      MODE_RK3, MODE_RK4: begin
        s9_next.npf = 52'(din.p) + 52'(hqp);
      end
      MODE_RKGEN: begin
        s9_next.npf = 52'(din.p) + 52'(hqp);
        s9_next.nvf = 52'(din.v) + 52'(hqv);
      end
      MODE_GROUND, MODE_EULER, MODE_MIDPOINT, MODE_SEMI, MODE_TRAP, MODE_VERLET: begin
        s9_next.bad = 1'b0;
      end
      default: begin
        s9_next.bad = 1'b1;
        s9_next.npf = 52'(din.p);
        s9_next.nvf = 52'(din.v);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s9r <= s9_next;
    end
  end

  assign sp = sat32(s9r.npf);
  assign sv = sat32(s9r.nvf);

  always_comb begin
    out_next.np  = $signed(sp[31:0]);
    out_next.nv  = $signed(sv[31:0]);
    out_next.sat = sp[32] | sv[32];
    out_next.bad = s9r.bad;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dout <= out_next;
    end
  end

endmodule

// ----- design/particle_axis_integrator.sv -----
// Top level of the particle axis integrator: configuration registers, pipeline control, datapath.
// The integrator is an eleven-stage pipeline that takes one input word per clock while the
// output side is ready and returns one result word per input. Every stage holds its own valid
// bit and advances whenever the stage after it is empty or moving, so bubbles close up during
// output stalls and the input keeps flowing until the pipeline is full. The depth is set by the
// general Runge-Kutta chain (three dependent coefficient products), the two-stage radix-16
// divide by six and the final step product.
// Configuration writes apply to words accepted after the write edge; later stages read the
// registers directly, so write them only while the pipeline is empty.
module particle_axis_integrator import pai_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // position, velocity, position_rate, acceleration, prior_position, prior_velocity,
  // prior_acceleration, 32 bits each
  input  logic [223:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // new_position, new_velocity, 32 bits each
  output logic [63:0]  m_axis_tdata,
  // saturated, bad_mode
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_addr,
  input  logic [20:0]  cfg_wr_data
);

  localparam int NS = 11;

  logic [3:0]         mode;
  logic [15:0]        time_step;
  logic [16:0]        verlet_keep;
  logic signed [20:0] lambda_coef;
  logic signed [20:0] inv_lambda;
  logic signed [20:0] half_minus_inv_lambda;
  logic signed [20:0] half_lambda;
  logic signed [20:0] one_minus_half_lambda;
  logic [16:0]        hh;
  logic signed [21:0] four_l;
  logic [31:0]        hsq;

  logic [NS-1:0] vld;
  logic [NS:0]   en;
  coef_t         cf;
  in_t           r0, r0_next;
  s2_t           s2;
  s6_t           s6;
  s8_t           s8;
  out_t          res;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode                  <= MODE_GROUND;
      time_step             <= 16'd1092;
      verlet_keep           <= 17'd65536;
      lambda_coef           <= 21'sd131072;
      inv_lambda            <= 21'sd32768;
      half_minus_inv_lambda <= 21'sd0;
      half_lambda           <= 21'sd65536;
      one_minus_half_lambda <= 21'sd0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_MODE:   mode                  <= cfg_wr_data[3:0];
        REG_STEP:   time_step             <= cfg_wr_data[15:0];
        REG_KEEP:   verlet_keep           <= cfg_wr_data[16:0];
        REG_LAMBDA: lambda_coef           <= $signed(cfg_wr_data);
        REG_INV:    inv_lambda            <= $signed(cfg_wr_data);
        REG_HMI:    half_minus_inv_lambda <= $signed(cfg_wr_data);
        REG_HALF:   half_lambda           <= $signed(cfg_wr_data);
        REG_OMH:    one_minus_half_lambda <= $signed(cfg_wr_data);
        default: begin
        end
      endcase
    end
  end

  assign hsq = 32'(time_step) * 32'(time_step);

  always_ff @(posedge clk) begin
    hh     <= 17'((33'(hsq) + 33'd32768) >> 16);
    four_l <= 22'sd262144 - 22'(lambda_coef);
  end

  always_comb begin
    cf.h      = time_step;
    cf.hh     = hh;
    cf.keep   = verlet_keep;
    cf.lam    = lambda_coef;
    cf.inv    = inv_lambda;
    cf.hmi    = half_minus_inv_lambda;
    cf.half   = half_lambda;
    cf.omh    = one_minus_half_lambda;
    cf.four_l = four_l;
  end

  always_comb begin
    en[NS] = m_axis_tready;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = ~vld[i] | en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_axis_tvalid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  always_comb begin
    r0_next.md = mode;
    r0_next.p  = $signed(s_axis_tdata[31:0]);
    r0_next.v  = $signed(s_axis_tdata[63:32]);
    r0_next.pd = $signed(s_axis_tdata[95:64]);
    r0_next.a  = $signed(s_axis_tdata[127:96]);
    r0_next.p0 = $signed(s_axis_tdata[159:128]);
    r0_next.v0 = $signed(s_axis_tdata[191:160]);
    r0_next.a0 = $signed(s_axis_tdata[223:192]);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r0 <= r0_next;
    end
  end

  pai_front u_front (.clk(clk), .en(en[2:1]), .cf(cf), .din(r0), .dout(s2));
  pai_lam   u_lam   (.clk(clk), .en(en[6:3]), .cf(cf), .din(s2), .dout(s6));
  pai_div6  u_div6  (.clk(clk), .en(en[8:7]), .din(s6), .dout(s8));
  pai_back  u_back  (.clk(clk), .en(en[10:9]), .cf(cf), .din(s8), .dout(res));

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld[NS-1];
  assign m_axis_tdata  = {res.nv, res.np};
  assign m_axis_tuser  = {res.bad, res.sat};

endmodule

// ----- design/pai_check.sv -----
// Port-level checker for the particle axis integrator and its bind to the top level.
module pai_check (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [223:0] s_axis_tdata,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [63:0]  m_axis_tdata,
  input logic [1:0]   m_axis_tuser,
  input logic         cfg_wr_en,
  input logic [2:0]   cfg_addr,
  input logic [20:0]  cfg_wr_data
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output word changed");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled while the output side is free");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("saturation reported on an unknown mode");

  a_clip_value: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      (m_axis_tdata[31:0] == 32'h7FFF_FFFF) || (m_axis_tdata[31:0] == 32'h8000_0000) ||
      (m_axis_tdata[63:32] == 32'h7FFF_FFFF) || (m_axis_tdata[63:32] == 32'h8000_0000))
    else $error("saturation flag without a clamped result");

endmodule

bind particle_axis_integrator pai_check u_check (.*);

// ----- sim/tb_particle_axis_integrator.sv -----
// Self-checking testbench for the particle axis integrator: random and directed words, all modes.
`timescale 1ns / 100ps
module tb_particle_axis_integrator import pai_pkg::*;;

  typedef struct {
    logic [3:0]          md;
    logic [15:0]         h;
    logic [16:0]         keep;
    logic signed [20:0]  lam, inv, hmi, half, omh;
  } cfg_t;

  typedef struct {
    logic [31:0] np;
    logic [31:0] nv;
    logic        sat;
    logic        bad;
  } res_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [223:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         cfg_wr_en = 1'b0;
  logic [2:0]   cfg_addr = '0;
  logic [20:0]  cfg_wr_data = '0;

  cfg_t         cur_cfg;
  logic [223:0] word_queue[$];
  res_t         expected_results[$];
  int           errors = 0;
  int           idle_cycles = 0;
  int           src_gap = 0;
  int           sink_gap = 0;
  bit           calm = 1'b0;
  bit           in_taken = 1'b0;

  particle_axis_integrator uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint round_shift(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint div6(longint x);
    longint q, r;
    q = x / 6;
    r = x % 6;
    if (r < 0) begin
      q -= 1;
      r += 6;
    end
    if (2 * r >= 6) q += 1;
    return q;
  endfunction

  function automatic logic [32:0] clamp(longint x);
    if (x > 64'sd2147483647) return {1'b1, 32'h7FFF_FFFF};
    if (x < -64'sd2147483648) return {1'b1, 32'h8000_0000};
    return {1'b0, x[31:0]};
  endfunction

  function automatic res_t integrate(logic [223:0] w, cfg_t c);
    longint p, v, pd, a, p0, v0, a0, h, hh, np, nv;
    longint k1, k2, k3, k4, cc, dd, fl, lm, sp, sv;
    logic [32:0] rp, rv;
    res_t r;
    p  = longint'(signed'(w[31:0]));
    v  = longint'(signed'(w[63:32]));
    pd = longint'(signed'(w[95:64]));
    a  = longint'(signed'(w[127:96]));
    p0 = longint'(signed'(w[159:128]));
    v0 = longint'(signed'(w[191:160]));
    a0 = longint'(signed'(w[223:192]));
    h  = longint'(c.h);
    hh = round_shift(h * h, 16);
    np = p;
    nv = v;
    r.bad = 1'b0;
    case (c.md)
      MODE_GROUND: begin
        np = p + round_shift(h * pd, 16) + round_shift(hh * a, 17);
        nv = v + round_shift(h * a, 16);
      end
      MODE_EULER: begin
        np = p + round_shift(h * pd, 16);
        nv = v + round_shift(h * a, 16);
      end
      MODE_MIDPOINT: begin
        np = p + round_shift(h * (v + round_shift(h * a, 17)), 16);
        nv = v + round_shift(h * a, 16);
      end
      MODE_RK3, MODE_RK4: begin
        k1 = v + round_shift(h * a, 16);
        k2 = v + round_shift(h * a, 17);
        np = p + round_shift(h * div6(2 * k1 + 4 * k2), 16);
        nv = v + round_shift(h * a, 16);
      end
      MODE_SEMI: begin
        nv = v + round_shift(h * a, 16);
        np = p + round_shift(h * nv, 16);
      end
      MODE_TRAP: begin
        np = p + round_shift(h * ((v + round_shift(h * a, 16)) + pd), 17);
        nv = v + round_shift(h * 2 * a, 17);
      end
      MODE_VERLET: begin
        np = p + round_shift((p - p0) * longint'(c.keep), 16) + round_shift(hh * a, 16);
        nv = v + round_shift((v - v0) * longint'(c.keep), 16)
               + round_shift(hh * (a - a0), 17);
      end
      MODE_RKGEN: begin
        lm = longint'(c.lam);
        fl = (longint'(4) <<< 16) - lm;
        cc = 2 * (round_shift(longint'(c.hmi) * a, 16) + round_shift(longint'(c.inv) * a, 16));
        dd = round_shift(longint'(c.omh) * a, 16) + round_shift(longint'(c.half) * cc, 16);
        k1 = v + round_shift(h * a, 16);
        k2 = v + round_shift(h * a, 17);
        k3 = v + round_shift(h * cc, 17);
        k4 = v + round_shift(h * dd, 16);
        sp = k1 + round_shift(fl * k2, 16) + round_shift(lm * k3, 16) + k4;
        sv = a + round_shift(fl * a, 16) + round_shift(lm * cc, 16) + dd;
        np = p + round_shift(h * div6(sp), 16);
        nv = v + round_shift(h * div6(sv), 16);
      end
      default: r.bad = 1'b1;
    endcase
    rp = clamp(np);
    rv = clamp(nv);
    r.np = rp[31:0];
    r.nv = rv[31:0];
    r.sat = rp[32] | rv[32];
    return r;
  endfunction

  // Registers are written at the falling edge while the pipeline is empty.
  task automatic write_reg(logic [2:0] idx, logic [20:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_MODE:   cur_cfg.md = val[3:0];
      REG_STEP:   cur_cfg.h = val[15:0];
      REG_KEEP:   cur_cfg.keep = val[16:0];
      REG_LAMBDA: cur_cfg.lam = val;
      REG_INV:    cur_cfg.inv = val;
      REG_HMI:    cur_cfg.hmi = val;
      REG_HALF:   cur_cfg.half = val;
      default:    cur_cfg.omh = val;
    endcase
  endtask

  task automatic drain();
    while (word_queue.size() != 0 || expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return $urandom_range(0, 255) - 128;
      3: return {{8{1'b0}}, 24'($urandom)} ^ {32{$urandom_range(0, 1) == 1}};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [223:0] rand_word();
    logic [223:0] w;
    for (int i = 0; i < 7; i++) w[i*32 +: 32] = rand_field();
    return w;
  endfunction

  task automatic rand_config();
    write_reg(REG_STEP, $urandom_range(0, 3) == 0 ? 21'(16'hFFFF) : 21'($urandom_range(0, 65535)));
    write_reg(REG_KEEP, $urandom_range(0, 3) == 0 ? 21'd65536 : 21'($urandom_range(0, 131071)));
    write_reg(REG_LAMBDA, 21'($urandom));
    write_reg(REG_INV, 21'($urandom));
    write_reg(REG_HMI, 21'($urandom));
    write_reg(REG_HALF, 21'($urandom));
    write_reg(REG_OMH, 21'($urandom));
  endtask

  initial begin
    cur_cfg = '{4'd0, 16'd1092, 17'd65536, 21'sd131072, 21'sd32768, 21'sd0, 21'sd65536, 21'sd0};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Directed: each mode on extreme and simple words with reset coefficients.
    for (int m = 0; m < 11; m++) begin
      write_reg(REG_MODE, 21'(m == 10 ? 15 : m));
      word_queue.push_back({7{32'h7FFF_FFFF}});
      word_queue.push_back({7{32'h8000_0000}});
      word_queue.push_back({32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h0002_0000, 32'h0000_8000, 32'h0010_0000});
      drain();
    end
    // Extreme register settings, then random settings per phase.
    for (int ph = 0; ph < 24; ph++) begin
      if (ph == 0) begin
        write_reg(REG_STEP, 21'h0FFFF);
        write_reg(REG_KEEP, 21'h1FFFF);
        write_reg(REG_LAMBDA, 21'h0FFFFF);
        write_reg(REG_INV, 21'h100000);
        write_reg(REG_HMI, 21'h0FFFFF);
        write_reg(REG_HALF, 21'h100000);
        write_reg(REG_OMH, 21'h0FFFFF);
      end else if (ph == 1) begin
        write_reg(REG_STEP, 21'd0);
        write_reg(REG_KEEP, 21'd0);
      end else begin
        rand_config();
      end
      if (ph == 20) calm = 1'b1;
      for (int m = 0; m < 11; m++) begin
        write_reg(REG_MODE, 21'(m < 9 ? m : $urandom_range(9, 15)));
        for (int i = 0; i < 4; i++) word_queue.push_back(rand_word());
        drain();
      end
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Source and sink sides: present the next word and drive the output ready, with random gaps.
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && !in_taken)) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        src_gap <= $urandom_range(0, 3);
        s_axis_tvalid <= 1'b0;
      end else if (word_queue.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word_queue[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      sink_gap <= $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Acceptance, prediction, checking and the idle watchdog at the rising edge.
  always @(posedge clk) begin
    res_t exp_r;
    in_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(integrate(s_axis_tdata, cur_cfg));
        void'(word_queue.pop_front());
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected word %h %b", $time, m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (m_axis_tdata[31:0] !== exp_r.np) begin
            $display("%0t: new_position expected %h actual %h", $time, exp_r.np, m_axis_tdata[31:0]);
            errors++;
          end
          if (m_axis_tdata[63:32] !== exp_r.nv) begin
            $display("%0t: new_velocity expected %h actual %h", $time, exp_r.nv,
                     m_axis_tdata[63:32]);
            errors++;
          end
          if (m_axis_tuser[0] !== exp_r.sat) begin
            $display("%0t: saturated expected %b actual %b", $time, exp_r.sat, m_axis_tuser[0]);
            errors++;
          end
          if (m_axis_tuser[1] !== exp_r.bad) begin
            $display("%0t: bad_mode expected %b actual %b", $time, exp_r.bad, m_axis_tuser[1]);
            errors++;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
          || (word_queue.size() == 0 && expected_results.size() == 0)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= 2000) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
